// ===== hdl/rvpt_pkg.sv =====
`timescale 1ns / 1ps

package rvpt_pkg;

   // Operation codes carried in the op field.
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // Field widths fixed by the interface.
   localparam int unsigned IDX_W = 10;
   localparam int unsigned VAL_W = 32;
   localparam int unsigned CSR_W = 11;

   // Entries per block; block and index arithmetic relies on a power of two.
   localparam int unsigned BLOCK_SIZE = 32;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RD,
      ST_CMP,
      ST_RSP
   } state_type;

   // Write-side controls toward the entry RAM.
   typedef struct packed {
      logic we;
      logic [VAL_W-1:0] wdata;
   } ram_ctl_type;

endpackage

// ===== hdl/rvpt_req_if.sv =====
`timescale 1ns / 1ps

interface rvpt_req_if;
   logic valid;
   logic ready;
   logic [1:0] op;
   logic [rvpt_pkg::IDX_W-1:0] lo;
   logic [rvpt_pkg::IDX_W-1:0] hi;
   logic signed [rvpt_pkg::VAL_W-1:0] value;

   modport source (output valid, op, lo, hi, value, input ready);
   modport sink (input valid, op, lo, hi, value, output ready);
endinterface

// ===== hdl/rvpt_rsp_if.sv =====
`timescale 1ns / 1ps

interface rvpt_rsp_if;
   logic valid;
   logic ready;
   logic found;

   modport source (output valid, found, input ready);
   modport sink (input valid, found, output ready);
endinterface

// ===== hdl/range_add_value_presence_table.sv =====
`timescale 1ns / 1ps
// Range add / value presence table.
// Requests arrive on req_if (op, lo, hi, value) with a valid/ready transfer.
// op 0 writes one entry, op 1 adds value to entries lo..hi, op 2 asks whether
// value occurs in lo..hi and returns one transfer on rsp_if carrying found.
// csr_we/csr_wdata set the number of entries in use (saturates at MAX_ENTRIES).
// Entries sit in a single-port RAM with a registered read.
// A write is made directly from the idle state. An add reads and writes back
// each entry of the first and last blocks of its range and handles each whole
// block between them at once, adding its amount to a per-block offset
// register. A query reads and compares every entry of the range, then loads
// the result. An invalid add finishes at once; an invalid query goes straight
// to loading a not-found result.
// req_if.ready is high only while the sequencer is idle.
// Reset clears the sequencer, the result valid and the block offsets and sets
// the entry count to 1024; entry contents are undefined until written.
// If the receiver stalls, the result is held in the output register and the
// next request is still taken; a further query waits before loading its
// result until the register is free.
module range_add_value_presence_table #(
   parameter int unsigned MAX_ENTRIES = 1024
) (
   input  logic clock,
   input  logic reset,
   rvpt_req_if.sink   req_if,
   rvpt_rsp_if.source rsp_if,
   input  logic                       csr_we,
   input  logic [rvpt_pkg::CSR_W-1:0] csr_wdata
);

   localparam int unsigned DEPTH =
      (MAX_ENTRIES + rvpt_pkg::BLOCK_SIZE - 1) / rvpt_pkg::BLOCK_SIZE * rvpt_pkg::BLOCK_SIZE;

   rvpt_pkg::ram_ctl_type ram_ctl;
   logic [$clog2(DEPTH)-1:0] ram_addr;
   logic [rvpt_pkg::VAL_W-1:0] ram_rdata;

   // Sequencer with block offsets.
   rvpt_ctrl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .ram_ctl(ram_ctl), .ram_addr(ram_addr), .ram_rdata(ram_rdata)
   );

   // Entry storage.
   rvpt_ram #(.WIDTH(rvpt_pkg::VAL_W), .DEPTH(DEPTH)) u_entries (
      .clock(clock), .we(ram_ctl.we), .addr(ram_addr),
      .wdata(ram_ctl.wdata), .rdata(ram_rdata)
   );

endmodule

// ===== hdl/rvpt_ram.sv =====
`timescale 1ns / 1ps

module rvpt_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port, registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/rvpt_ctrl.sv =====
`timescale 1ns / 1ps

module rvpt_ctrl #(
   parameter int unsigned MAX_ENTRIES = 1024
) (
   input  logic clock,
   input  logic reset,
   rvpt_req_if.sink   req_if,
   rvpt_rsp_if.source rsp_if,
   input  logic                        csr_we,
   input  logic [rvpt_pkg::CSR_W-1:0]  csr_wdata,
   output rvpt_pkg::ram_ctl_type       ram_ctl,
   output logic [$clog2((MAX_ENTRIES + rvpt_pkg::BLOCK_SIZE - 1) / rvpt_pkg::BLOCK_SIZE
                        * rvpt_pkg::BLOCK_SIZE)-1:0] ram_addr,
   input  logic [rvpt_pkg::VAL_W-1:0]  ram_rdata
);

   localparam int unsigned NB   = (MAX_ENTRIES + rvpt_pkg::BLOCK_SIZE - 1) / rvpt_pkg::BLOCK_SIZE;
   localparam int unsigned AW   = $clog2(NB * rvpt_pkg::BLOCK_SIZE);
   localparam int unsigned BW   = $clog2(rvpt_pkg::BLOCK_SIZE);
   localparam int unsigned NBW  = (NB > 1) ? $clog2(NB) : 1;
   localparam int unsigned CW0  = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned CW   = (CW0 > rvpt_pkg::CSR_W) ? CW0 : rvpt_pkg::CSR_W;
   localparam int unsigned XW   = CW + 1;
   localparam int unsigned VW   = rvpt_pkg::VAL_W;

   rvpt_pkg::state_type state_ff, state_in;
   logic [rvpt_pkg::CSR_W-1:0] csr_ff;
   logic          add_ff, add_in;
   logic [XW-1:0] idx_ff, idx_in;
   logic [XW-1:0] hi_ff, hi_in;
   logic [XW-1:0] bl_ff, bl_in, bh_ff, bh_in;
   logic [VW-1:0] val_ff, val_in;
   logic          hit_ff, hit_in;
   logic          rspv_ff, rspv_in;
   logic          found_ff, found_in;
   logic [VW-1:0] off_ff [NB];
   logic          off_we;
   logic [VW-1:0] off_wdata;

   logic [CW-1:0] eff;
   logic [XW-1:0] lo_x, hi_x, blk;
   logic [NBW-1:0] blk_i;
   logic          take, rng_ok, whole, slot_free;
   logic [VW-1:0] vis;

   // Effective entry count saturates at MAX_ENTRIES.
   assign eff = (CW'(csr_ff) > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(csr_ff);

   assign lo_x   = XW'(req_if.lo);
   assign hi_x   = XW'(req_if.hi);
   assign rng_ok = (lo_x <= hi_x) && (hi_x < XW'(eff));
   assign take   = req_if.valid && req_if.ready;

   assign blk   = idx_ff >> BW;
   assign blk_i = blk[NBW-1:0];
   assign whole = add_ff && (blk > bl_ff) && (blk < bh_ff);
   assign vis   = ram_rdata + off_ff[blk_i];
   assign slot_free = !rspv_ff || rsp_if.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rvpt_pkg::ST_IDLE: begin
            if (take && req_if.op == rvpt_pkg::OP_QUERY) begin
               state_in = rng_ok ? rvpt_pkg::ST_RD : rvpt_pkg::ST_RSP;
            end else if (take && req_if.op == rvpt_pkg::OP_ADD && rng_ok) begin
               state_in = rvpt_pkg::ST_RD;
            end
         end
         rvpt_pkg::ST_RD: begin
            if (idx_ff > hi_ff) begin
               state_in = add_ff ? rvpt_pkg::ST_IDLE : rvpt_pkg::ST_RSP;
            end else if (!whole) begin
               state_in = rvpt_pkg::ST_CMP;
            end
         end
         rvpt_pkg::ST_CMP: state_in = rvpt_pkg::ST_RD;
         rvpt_pkg::ST_RSP: begin
            if (slot_free) begin
               state_in = rvpt_pkg::ST_IDLE;
            end
         end
         default: state_in = rvpt_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      add_in    = add_ff;
      idx_in    = idx_ff;
      hi_in     = hi_ff;
      bl_in     = bl_ff;
      bh_in     = bh_ff;
      val_in    = val_ff;
      hit_in    = hit_ff;
      rspv_in   = rspv_ff && !rsp_if.ready;
      found_in  = found_ff;
      off_we    = 1'b0;
      off_wdata = off_ff[blk_i] + val_ff;
      ram_ctl.we    = 1'b0;
      ram_ctl.wdata = vis;
      ram_addr  = idx_ff[AW-1:0];
      req_if.ready = (state_ff == rvpt_pkg::ST_IDLE);
      case (state_ff)
         rvpt_pkg::ST_IDLE: begin
            add_in = (req_if.op == rvpt_pkg::OP_ADD);
            idx_in = lo_x;
            hi_in  = hi_x;
            bl_in  = lo_x >> BW;
            bh_in  = hi_x >> BW;
            val_in = req_if.value;
            hit_in = 1'b0;
            // A write goes straight to the RAM.
            ram_addr      = lo_x[AW-1:0];
            ram_ctl.wdata = req_if.value;
            ram_ctl.we    = take && (req_if.op == rvpt_pkg::OP_WRITE) && (lo_x < XW'(eff));
         end
         rvpt_pkg::ST_RD: begin
            // Whole blocks in an add take the amount in their offset.
            if (idx_ff <= hi_ff && whole) begin
               off_we = 1'b1;
               idx_in = (blk + XW'(1)) << BW;
            end
         end
         rvpt_pkg::ST_CMP: begin
            if (add_ff) begin
               ram_ctl.we    = 1'b1;
               ram_ctl.wdata = ram_rdata + val_ff;
            end else if (vis == val_ff) begin
               hit_in = 1'b1;
            end
            idx_in = idx_ff + XW'(1);
         end
         rvpt_pkg::ST_RSP: begin
            if (slot_free) begin
               rspv_in  = 1'b1;
               found_in = hit_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rvpt_pkg::ST_IDLE;
         csr_ff   <= rvpt_pkg::CSR_W'(1024);
         rspv_ff  <= 1'b0;
         for (int i = 0; i < NB; i++) begin
            off_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rspv_ff  <= rspv_in;
         if (csr_we) begin
            csr_ff <= csr_wdata;
         end
         if (off_we) begin
            off_ff[blk_i] <= off_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      add_ff   <= add_in;
      idx_ff   <= idx_in;
      hi_ff    <= hi_in;
      bl_ff    <= bl_in;
      bh_ff    <= bh_in;
      val_ff   <= val_in;
      hit_ff   <= hit_in;
      found_ff <= found_in;
   end

   assign rsp_if.valid = rspv_ff;
   assign rsp_if.found = found_ff;

endmodule

// ===== hdl/rvpt_checker.sv =====
`timescale 1ns / 1ps

module rvpt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic found
);

   // A pending result stays until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");

   // A stalled result keeps its value.
   a_found_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(found)) else $error("found changed");

   // No result right after reset.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("rsp after reset");

   // A new result is loaded only while the sequencer is busy.
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready)) else $error("rsp while idle");

endmodule

bind range_add_value_presence_table rvpt_checker u_rvpt_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_if.valid), .req_ready(req_if.ready),
   .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready),
   .found(rsp_if.found)
);
